// ----- rtl/ipp_pkg.sv -----
// ----------------------------------------------------------------------------
// ipp_pkg
// types, character codes and token helpers shared by the address parser
// ----------------------------------------------------------------------------
package ipp_pkg;

  localparam int GROUPS      = 8;
  localparam int GROUP_IDX_W = 3;
  localparam int COUNT_W     = 4;
  localparam int TEXT_CNT_W  = 6;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    logic [TEXT_CNT_W-1:0]          text_count;
    logic                           too_long;
    logic                           saw_colon;
    logic                           saw_dot;
    logic [1:0]                     octet_index;
    logic [7:0]                     octet_value;
    logic [1:0]                     octet_digits;
    logic [23:0]                    done_octets;
    logic                           quad_bad;
    logic [15:0]                    group_value;
    logic [2:0]                     group_digits;
    logic                           token_dotted;
    logic [GROUPS-1:0][15:0]        head_groups;
    logic [GROUPS-1:0][15:0]        tail_groups;
    logic [COUNT_W-1:0]             head_count;
    logic [COUNT_W-1:0]             tail_count;
    logic                           in_tail;
    logic [1:0]                     colon_run;
    logic                           six_bad;
  } parse_state_t;

  function automatic logic quad_ok(parse_state_t s);
    return !s.quad_bad && (s.octet_index == 2'd3) && (s.octet_digits != 2'd0);
  endfunction

  function automatic parse_state_t quad_clear(parse_state_t s);
    parse_state_t r;
    r = s;
    r.octet_index  = '0;
    r.octet_value  = '0;
    r.octet_digits = '0;
    r.done_octets  = '0;
    r.quad_bad     = 1'b0;
    return r;
  endfunction

  // group lists keep their contents, only the counts say what is live
  function automatic parse_state_t state_clear(parse_state_t s);
    parse_state_t r;
    r = quad_clear(s);
    r.text_count   = '0;
    r.too_long     = 1'b0;
    r.saw_colon    = 1'b0;
    r.saw_dot      = 1'b0;
    r.group_value  = '0;
    r.group_digits = '0;
    r.token_dotted = 1'b0;
    r.head_count   = '0;
    r.tail_count   = '0;
    r.in_tail      = 1'b0;
    r.colon_run    = '0;
    r.six_bad      = 1'b0;
    return r;
  endfunction

  // tail groups shift in at the top so they end up right-aligned
  function automatic parse_state_t push_group(parse_state_t s, logic [15:0] v);
    parse_state_t r;
    r = s;
    if (r.in_tail) begin
      if (r.tail_count >= COUNT_W'(GROUPS)) begin
        r.six_bad = 1'b1;
      end else begin
        r.tail_groups = {v, r.tail_groups[GROUPS-1:1]};
        r.tail_count  = r.tail_count + 1'b1;
      end
    end else begin
      if (r.head_count >= COUNT_W'(GROUPS)) begin
        r.six_bad = 1'b1;
      end else begin
        r.head_groups[r.head_count[GROUP_IDX_W-1:0]] = v;
        r.head_count = r.head_count + 1'b1;
      end
    end
    return r;
  endfunction

  function automatic parse_state_t close_token(parse_state_t s, logic final_tok);
    parse_state_t       r;
    logic [COUNT_W-1:0] cnt;
    logic [31:0]        q;
    r   = s;
    cnt = r.in_tail ? r.tail_count : r.head_count;
    q   = {r.done_octets, r.octet_value};
    if (r.token_dotted) begin
      if (!final_tok || !quad_ok(r) || (cnt > COUNT_W'(GROUPS - 2))) begin
        r.six_bad = 1'b1;
      end else begin
        r = push_group(r, q[31:16]);
        r = push_group(r, q[15:0]);
      end
    end else begin
      if ((r.group_digits == 3'd0) || (r.group_digits > 3'd4)) begin
        r.six_bad = 1'b1;
      end else begin
        r = push_group(r, r.group_value);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/ipp_parse.sv -----
// ----------------------------------------------------------------------------
// ipp_parse
// input register and per-character parser state update; hands the final
// parser state of each text to the verdict stage
// ----------------------------------------------------------------------------
module ipp_parse #(
  parameter int MAX_TEXT_LEN = 45
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_char_code,
  input  logic                  in_char_present,
  input  logic                  in_last,
  output logic                  snap_valid,
  input  logic                  snap_ready,
  output ipp_pkg::parse_state_t snap_state
);
  import ipp_pkg::*;

  localparam logic [TEXT_CNT_W-1:0] MAX_LEN = TEXT_CNT_W'(MAX_TEXT_LEN);
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;

  logic         iv_r;
  logic [7:0]   ic_r;
  logic         ip_r;
  logic         il_r;
  parse_state_t st_r;
  parse_state_t st_nxt;
  logic         snap_v_r;
  parse_state_t snap_r;
  logic         snap_free;
  logic         take;

  assign snap_free  = !snap_v_r || snap_ready;
  assign take       = iv_r && (!il_r || snap_free);
  assign in_ready   = !iv_r || take;
  assign snap_valid = snap_v_r;
  assign snap_state = snap_r;

  always_comb begin
    parse_state_t          s;
    logic [TEXT_CNT_W-1:0] prior_cnt;
    logic                  is_dig;
    logic                  is_hex;
    logic [3:0]            h;
    logic [11:0]           v;
    s         = st_r;
    prior_cnt = st_r.text_count;
    is_dig    = (ic_r >= CH_ZERO) && (ic_r <= CH_NINE);
    h         = 4'(ic_r - CH_ZERO);
    is_hex    = is_dig;
    if ((ic_r >= CH_LA) && (ic_r <= CH_LF)) begin
      is_hex = 1'b1;
      h      = 4'(ic_r - CH_LA + 8'd10);
    end else if ((ic_r >= CH_UA) && (ic_r <= CH_UF)) begin
      is_hex = 1'b1;
      h      = 4'(ic_r - CH_UA + 8'd10);
    end
    v = 12'(s.octet_value) * 12'd10 + 12'(ic_r - CH_ZERO);
    if (ip_r) begin
      if (s.text_count >= MAX_LEN) begin
        s.too_long = 1'b1;
      end else begin
        s.text_count = s.text_count + 1'b1;
      end
      if (ic_r == CH_COLON) begin
        s.saw_colon = 1'b1;
        case (st_r.colon_run)
          2'd0: begin
            if (prior_cnt != '0) s = close_token(s, 1'b0);
            s.colon_run = 2'd1;
          end
          2'd1: begin
            if (s.in_tail) s.six_bad = 1'b1;
            s.in_tail   = 1'b1;
            s.colon_run = 2'd2;
          end
          default: s.six_bad = 1'b1;
        endcase
        s.group_value  = '0;
        s.group_digits = '0;
        s.token_dotted = 1'b0;
        s = quad_clear(s);
      end else begin
        // dotted-quad sub-parser
        if (!s.quad_bad) begin
          if (ic_r == CH_DOT) begin
            if ((s.octet_digits == 2'd0) || (s.octet_index == 2'd3)) begin
              s.quad_bad = 1'b1;
            end else begin
              s.done_octets  = {s.done_octets[15:0], s.octet_value};
              s.octet_index  = s.octet_index + 1'b1;
              s.octet_value  = '0;
              s.octet_digits = '0;
            end
          end else if (is_dig) begin
            if ((s.octet_digits == 2'd3) || (v > 12'd255)) begin
              s.quad_bad = 1'b1;
            end else begin
              s.octet_value  = v[7:0];
              s.octet_digits = s.octet_digits + 1'b1;
            end
          end else begin
            s.quad_bad = 1'b1;
          end
        end
        if ((st_r.colon_run == 2'd1) && (prior_cnt == TEXT_CNT_W'(1))) s.six_bad = 1'b1;
        s.colon_run = '0;
        if (ic_r == CH_DOT) begin
          s.saw_dot      = 1'b1;
          s.token_dotted = 1'b1;
        end else if (!is_hex) begin
          s.six_bad = 1'b1;
        end else begin
          s.group_value = {s.group_value[11:0], h};
          if (s.group_digits != 3'd7) s.group_digits = s.group_digits + 1'b1;
        end
      end
    end
    st_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r     <= 1'b0;
      snap_v_r <= 1'b0;
      st_r     <= state_clear(st_r);
    end else begin
      if (in_ready) iv_r <= in_valid;
      if (take) begin
        st_r <= il_r ? state_clear(st_nxt) : st_nxt;
      end
      if (take && il_r) begin
        snap_v_r <= 1'b1;
      end else if (snap_ready) begin
        snap_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ic_r <= in_char_code;
      ip_r <= in_char_present;
      il_r <= in_last;
    end
    if (take && il_r) snap_r <= st_nxt;
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && il_r |=> (st_r.text_count == '0) && !st_r.six_bad && !st_r.in_tail)
    else $error("parser state not cleared after final character");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.text_count <= MAX_LEN)
    else $error("text count beyond length limit");

endmodule

// ----- rtl/ipp_verdict.sv -----
// ----------------------------------------------------------------------------
// ipp_verdict
// closes the last ipv6 token, checks the group count or the dotted quad and lays out the
// address into the result register
// ----------------------------------------------------------------------------
module ipp_verdict (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  snap_valid,
  output logic                  snap_ready,
  input  ipp_pkg::parse_state_t snap_state,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_valid_res,
  output logic                  out_family,
  output logic [63:0]           out_addr_high,
  output logic [63:0]           out_addr_low
);
  import ipp_pkg::*;

  logic        ov_r;
  logic        ok_r;
  logic        fam_r;
  logic [63:0] hi_r;
  logic [63:0] lo_r;
  logic        ok_nxt;
  logic        fam_nxt;
  logic [63:0] hi_nxt;
  logic [63:0] lo_nxt;

  assign snap_ready    = !ov_r || out_ready;
  assign out_valid     = ov_r;
  assign out_valid_res = ok_r;
  assign out_family    = fam_r;
  assign out_addr_high = hi_r;
  assign out_addr_low  = lo_r;

  always_comb begin
    parse_state_t                s;
    logic [COUNT_W:0]            total;
    logic [GROUPS-1:0][15:0]     g;
    s       = snap_state;
    ok_nxt  = 1'b0;
    fam_nxt = 1'b0;
    hi_nxt  = '0;
    lo_nxt  = '0;
    g       = '0;
    total   = '0;
    if (!s.too_long && (s.text_count != '0)) begin
      if (!s.saw_colon) begin
        if (s.saw_dot && quad_ok(s)) begin
          ok_nxt = 1'b1;
          hi_nxt = {s.done_octets, s.octet_value, 32'd0};
        end
      end else begin
        if (s.colon_run == 2'd1) begin
          s.six_bad = 1'b1;
        end else if (s.colon_run == 2'd0) begin
          s = close_token(s, 1'b1);
        end
        total = {1'b0, s.head_count} + {1'b0, s.tail_count};
        if (!s.six_bad && (s.in_tail ? (total <= (COUNT_W+1)'(GROUPS - 1))
                                     : (total == (COUNT_W+1)'(GROUPS)))) begin
          for (int j = 0; j < GROUPS; j++) begin
            if (COUNT_W'(j) < s.head_count) begin
              g[GROUPS-1-j] = s.head_groups[j];
            end else if ((COUNT_W+1)'(j) + {1'b0, s.tail_count} >= (COUNT_W+1)'(GROUPS)) begin
              g[GROUPS-1-j] = s.tail_groups[j];
            end
          end
          ok_nxt  = 1'b1;
          fam_nxt = 1'b1;
          hi_nxt  = g[GROUPS-1:GROUPS/2];
          lo_nxt  = g[GROUPS/2-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (snap_valid && snap_ready) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      ok_r  <= ok_nxt;
      fam_r <= fam_nxt;
      hi_r  <= hi_nxt;
      lo_r  <= lo_nxt;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !ok_r |-> !fam_r && (hi_r == '0) && (lo_r == '0))
    else $error("invalid verdict carries a non-zero address");

  a_v4_layout: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ok_r && !fam_r |-> (lo_r == '0) && (hi_r[31:0] == '0))
    else $error("ipv4 address outside top 32 bits");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    snap_valid && snap_ready |=> ov_r)
    else $error("verdict lost on load");

endmodule

// ----- rtl/ip_address_text_parser_top.sv -----
// ----------------------------------------------------------------------------
// ip_address_text_parser_top
// ipv4 / ipv6 address text parser, one character per word, one verdict per
// text on the word marked last
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   in_char_code, in_char_present, in_last
//  out      output     out_valid / out_ready out_valid_res, out_family,
//                                            out_addr_high, out_addr_low
//
//  one character word accepted per cycle, back to back, but for the last-word stall below
//  the verdict passes the input register, then the parser update into the snapshot
//  register, then token close and address layout into the result register
//  synchronous active-low reset clears all control state, no clearing sweep
//  a held result stalls intake only when a further last word reaches the
//  parser; ordinary characters keep flowing
// ----------------------------------------------------------------------------
module ip_address_text_parser_top #(
  parameter int MAX_TEXT_LEN = 45
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_char_present,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic        out_family,
  output logic [63:0] out_addr_high,
  output logic [63:0] out_addr_low
);
  import ipp_pkg::*;

  logic         snap_valid;
  logic         snap_ready;
  parse_state_t snap_state;

  ipp_parse #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .in_char_present (in_char_present),
    .in_last         (in_last),
    .snap_valid      (snap_valid),
    .snap_ready      (snap_ready),
    .snap_state      (snap_state)
  );

  ipp_verdict u_verdict (
    .clk           (clk),
    .rst_n         (rst_n),
    .snap_valid    (snap_valid),
    .snap_ready    (snap_ready),
    .snap_state    (snap_state),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_valid_res (out_valid_res),
    .out_family    (out_family),
    .out_addr_high (out_addr_high),
    .out_addr_low  (out_addr_low)
  );

endmodule
